FILE: rtl/core/sgd_pkg.sv
`timescale 1ns / 1ps
package sgd_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int PIX_BITS   = 8;
    localparam int COL_BITS   = $clog2(MAX_WIDTH);
    localparam int ROW_BITS   = 11;
    localparam int CFG_BITS   = 11;
    localparam int GRAD_BITS  = 11;
    localparam int ABS_BITS   = 10;
    localparam int SQ_BITS    = 22;
    localparam int ROOT_BITS  = 11;
    localparam int POS_BITS   = 10;
    localparam int PROD_BITS  = 28;

    localparam logic [17:0] TAN_LO = 18'd27146;
    localparam logic [17:0] TAN_HI = 18'd158218;

    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_FLUSH = 1'b1;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    localparam logic [1:0] DIR_HORZ     = 2'd0;
    localparam logic [1:0] DIR_DIAG_POS = 2'd1;
    localparam logic [1:0] DIR_VERT     = 2'd2;
    localparam logic [1:0] DIR_DIAG_NEG = 2'd3;

    typedef logic [PIX_BITS-1:0] pix_t;

    // one line-store entry: older row and newer row at the same column
    typedef struct packed {
        pix_t mid;
        pix_t top;
    } line_entry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPD,
        ST_CALC,
        ST_SQRT
    } sgd_state_t;

endpackage

FILE: rtl/core/sgd_line_ram.sv
`timescale 1ns / 1ps
module sgd_line_ram (
    input  logic                        aclk,
    input  logic                        en,
    input  logic                        we,
    input  logic [sgd_pkg::COL_BITS-1:0] addr,
    input  sgd_pkg::line_entry_t        wdata,
    output sgd_pkg::line_entry_t        rdata
);
    import sgd_pkg::*;

    line_entry_t mem [MAX_WIDTH];

    always_ff @(posedge aclk) begin
        if (en && we) begin
            mem[addr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (en && !we) begin
            rdata <= mem[addr];
        end
    end

endmodule

FILE: rtl/core/sgd_sqrt.sv
`timescale 1ns / 1ps
module sgd_sqrt (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [sgd_pkg::SQ_BITS-1:0]   operand,
    output logic                          busy,
    output logic [sgd_pkg::ROOT_BITS-1:0] root
);
    import sgd_pkg::*;

    logic [SQ_BITS-1:0] v_reg, v_next;
    logic [SQ_BITS-1:0] r_reg, r_next;
    logic [SQ_BITS-1:0] b_reg, b_next;
    logic [SQ_BITS:0]   trial;

    assign busy = (b_reg != '0);
    assign root = r_reg[ROOT_BITS-1:0];
    assign trial = {1'b0, r_reg} + {1'b0, b_reg};

    // digit-by-digit root, one bit pair per cycle
    always_comb begin
        v_next = v_reg;
        r_next = r_reg;
        b_next = b_reg;
        if (start) begin
            v_next = operand;
            r_next = '0;
            b_next = SQ_BITS'(1) << (SQ_BITS - 2);
        end else if (busy) begin
            if ({1'b0, v_reg} >= trial) begin
                v_next = v_reg - trial[SQ_BITS-1:0];
                r_next = (r_reg >> 1) + b_reg;
            end else begin
                r_next = r_reg >> 1;
            end
            b_next = b_reg >> 2;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_reg <= '0;
        end else begin
            b_reg <= b_next;
        end
        v_reg <= v_next;
        r_reg <= r_next;
    end

endmodule

FILE: rtl/core/sobel_gradient_direction.sv
`timescale 1ns / 1ps
// flow: an input transaction reads the line store, then the window is updated, then
// the products are formed and the square root iterates; a waiting result stalls the input
// the block takes a new item only once it is through with the last one, whether or not
// that item makes a result
// reset: synchronous active-low aresetn clears counters, window and control;
// registers return to width 320, height 240; line store is not cleared
module sobel_gradient_direction (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] pixel
    input  logic [0:0]  s_tuser,   // [0] kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // grad_x, grad_y, strength, magnitude, direction,
                                   // row_index, col_index from bit 0 up, zero fill
    output logic        m_tlast,   // frame_last
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import sgd_pkg::*;

    sgd_state_t state_reg, state_next;

    logic [CFG_BITS-1:0] width_cfg_reg, height_cfg_reg;
    logic [CFG_BITS-1:0] eff_w, eff_h;

    logic [COL_BITS-1:0] in_col_reg, in_col_next;
    logic [ROW_BITS-1:0] in_row_reg, in_row_next;
    logic [COL_BITS-1:0] out_col_reg, out_col_next;
    logic [ROW_BITS-1:0] out_row_reg, out_row_next;

    logic kind_reg;
    pix_t pix_reg;
    pix_t win_reg [3][3];
    pix_t win_next [3][3];
    pix_t emit_win [3][3];

    logic signed [GRAD_BITS-1:0] gx_reg, gy_reg, gx_next, gy_next;
    logic [POS_BITS-1:0] row_idx_reg, col_idx_reg;
    logic last_reg;
    logic [GRAD_BITS-1:0] strength_reg;
    logic [1:0] dir_reg;

    logic        m_tvalid_reg;
    logic [71:0] m_tdata_reg;
    logic        m_tlast_reg;

    logic in_accept, restart, flush_ok, emit, col_zero, out_wrap;
    logic ram_en, ram_we;
    logic [COL_BITS-1:0] ram_addr, flush_addr;
    line_entry_t ram_wdata, ram_rdata;
    pix_t top_v, mid_v;

    logic [ABS_BITS-1:0] ax, ay;
    logic [SQ_BITS-1:0]  sq_sum;
    logic [PROD_BITS-1:0] ay_sh, lo_p, hi_p;
    logic [1:0] dir_c;
    logic sqrt_start, sqrt_busy;
    logic [ROOT_BITS-1:0] sqrt_root;
    logic out_free;

    // configuration
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_HEIGHT) ? 32'(height_cfg_reg) : 32'(width_cfg_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_cfg_reg  <= CFG_BITS'(320);
            height_cfg_reg <= CFG_BITS'(240);
        end else if (psel && penable && pwrite && pready) begin
            if (paddr[2] == REG_HEIGHT) begin
                height_cfg_reg <= pwdata[CFG_BITS-1:0];
            end else begin
                width_cfg_reg <= pwdata[CFG_BITS-1:0];
            end
        end
    end

    always_comb begin
        eff_w = width_cfg_reg;
        if (width_cfg_reg < CFG_BITS'(3)) eff_w = CFG_BITS'(3);
        if (width_cfg_reg > CFG_BITS'(MAX_WIDTH)) eff_w = CFG_BITS'(MAX_WIDTH);
        eff_h = height_cfg_reg;
        if (height_cfg_reg < CFG_BITS'(3)) eff_h = CFG_BITS'(3);
        if (height_cfg_reg > CFG_BITS'(MAX_HEIGHT)) eff_h = CFG_BITS'(MAX_HEIGHT);
    end

    // input side
    assign in_accept = s_tvalid && s_tready;
    assign restart   = (in_row_reg >= eff_h);
    assign flush_ok  = (in_row_reg >= eff_h) && (out_row_reg < eff_h);
    assign out_wrap  = ({1'b0, out_col_reg} + CFG_BITS'(1)) >= eff_w;
    assign flush_addr = out_wrap ? '0 : out_col_reg + COL_BITS'(1);
    assign out_free  = !m_tvalid_reg || m_tready;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_accept && (s_tuser[0] == KIND_PIXEL || flush_ok)) begin
                    state_next = ST_UPD;
                end
            end
            ST_UPD:  state_next = emit ? ST_CALC : ST_IDLE;
            ST_CALC: state_next = ST_SQRT;
            ST_SQRT: begin
                if (!sqrt_busy && out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        s_tready   = 1'b0;
        ram_en     = 1'b0;
        ram_we     = 1'b0;
        ram_addr   = in_col_reg;
        sqrt_start = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                ram_en   = in_accept;
                if (s_tuser[0] == KIND_FLUSH) begin
                    ram_addr = flush_addr;
                end else begin
                    ram_addr = restart ? '0 : in_col_reg;
                end
            end
            ST_UPD: begin
                ram_en = (kind_reg == KIND_PIXEL);
                ram_we = (kind_reg == KIND_PIXEL);
            end
            ST_CALC: sqrt_start = 1'b1;
            ST_SQRT: ;
            default: ;
        endcase
    end

    sgd_line_ram u_line_ram (
        .aclk  (aclk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // window update and emit window
    assign col_zero = (in_col_reg == '0);
    assign top_v = (in_row_reg >= ROW_BITS'(2)) ? ram_rdata.top : '0;
    assign mid_v = (in_row_reg >= ROW_BITS'(1)) ? ram_rdata.mid : '0;
    assign ram_wdata = '{mid: pix_reg, top: ram_rdata.mid};

    always_comb begin
        pix_t v [3];
        logic wrap;
        if (kind_reg == KIND_PIXEL) begin
            v[0] = top_v;
            v[1] = mid_v;
            v[2] = pix_reg;
            wrap = col_zero;
            emit = col_zero ? (in_row_reg >= ROW_BITS'(2)) : (in_row_reg >= ROW_BITS'(1));
        end else begin
            v[0] = ram_rdata.top;
            v[1] = ram_rdata.mid;
            v[2] = '0;
            wrap = out_wrap;
            emit = 1'b1;
        end
        for (int r = 0; r < 3; r++) begin
            if (wrap) begin
                emit_win[r][0] = win_reg[r][1];
                emit_win[r][1] = win_reg[r][2];
                emit_win[r][2] = '0;
                win_next[r][0] = '0;
                win_next[r][1] = '0;
                win_next[r][2] = v[r];
            end else begin
                win_next[r][0] = win_reg[r][1];
                win_next[r][1] = win_reg[r][2];
                win_next[r][2] = v[r];
                emit_win[r][0] = win_next[r][0];
                emit_win[r][1] = win_next[r][1];
                emit_win[r][2] = win_next[r][2];
            end
        end
        gx_next = GRAD_BITS'($signed({1'b0,
                      {2'b0, emit_win[0][2]} + {1'b0, emit_win[1][2], 1'b0}
                      + {2'b0, emit_win[2][2]}}))
                - GRAD_BITS'($signed({1'b0,
                      {2'b0, emit_win[0][0]} + {1'b0, emit_win[1][0], 1'b0}
                      + {2'b0, emit_win[2][0]}}));
        gy_next = GRAD_BITS'($signed({1'b0,
                      {2'b0, emit_win[0][0]} + {1'b0, emit_win[0][1], 1'b0}
                      + {2'b0, emit_win[0][2]}}))
                - GRAD_BITS'($signed({1'b0,
                      {2'b0, emit_win[2][0]} + {1'b0, emit_win[2][1], 1'b0}
                      + {2'b0, emit_win[2][2]}}));
    end

    // counters
    always_comb begin
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (state_reg == ST_IDLE && in_accept && s_tuser[0] == KIND_PIXEL && restart) begin
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
        end else if (state_reg == ST_UPD) begin
            if (kind_reg == KIND_PIXEL) begin
                if (({1'b0, in_col_reg} + CFG_BITS'(1)) >= eff_w) begin
                    in_col_next = '0;
                    in_row_next = in_row_reg + ROW_BITS'(1);
                end else begin
                    in_col_next = in_col_reg + COL_BITS'(1);
                end
            end
            if (emit) begin
                if (out_wrap) begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + ROW_BITS'(1);
                end else begin
                    out_col_next = out_col_reg + COL_BITS'(1);
                end
            end
            // end of drain starts a fresh frame
            if (kind_reg == KIND_FLUSH && out_row_next >= eff_h) begin
                in_col_next  = '0;
                in_row_next  = '0;
                out_col_next = '0;
                out_row_next = '0;
            end
        end
    end

    // magnitude and direction products
    assign ax = gx_reg[GRAD_BITS-1] ? ABS_BITS'(-gx_reg) : ABS_BITS'(gx_reg);
    assign ay = gy_reg[GRAD_BITS-1] ? ABS_BITS'(-gy_reg) : ABS_BITS'(gy_reg);
    assign sq_sum = SQ_BITS'(ax * ax) + SQ_BITS'(ay * ay);
    assign ay_sh  = PROD_BITS'({ay, 16'b0});
    assign lo_p   = PROD_BITS'(ax * TAN_LO);
    assign hi_p   = PROD_BITS'(ax * TAN_HI);

    always_comb begin
        logic gx_pos, gy_pos;
        gx_pos = !gx_reg[GRAD_BITS-1] && (gx_reg != '0);
        gy_pos = !gy_reg[GRAD_BITS-1] && (gy_reg != '0);
        priority if (gx_reg == '0) begin
            dir_c = DIR_VERT;
        end else if (ay_sh <= lo_p) begin
            dir_c = DIR_HORZ;
        end else if (gx_pos == gy_pos) begin
            dir_c = (ay_sh <= hi_p) ? DIR_DIAG_POS : DIR_VERT;
        end else begin
            dir_c = (ay_sh < hi_p) ? DIR_DIAG_NEG : DIR_VERT;
        end
    end

    sgd_sqrt u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sqrt_start),
        .operand (sq_sum),
        .busy    (sqrt_busy),
        .root    (sqrt_root)
    );

    // registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            m_tvalid_reg <= 1'b0;
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    win_reg[r][c] <= '0;
                end
            end
        end else begin
            state_reg   <= state_next;
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            if (state_reg == ST_IDLE && in_accept && s_tuser[0] == KIND_PIXEL && restart) begin
                for (int r = 0; r < 3; r++) begin
                    for (int c = 0; c < 3; c++) begin
                        win_reg[r][c] <= '0;
                    end
                end
            end else if (state_reg == ST_UPD) begin
                for (int r = 0; r < 3; r++) begin
                    for (int c = 0; c < 3; c++) begin
                        if (kind_reg == KIND_FLUSH && out_row_next == '0 && emit
                                && out_row_reg != '0) begin
                            win_reg[r][c] <= '0;
                        end else begin
                            win_reg[r][c] <= win_next[r][c];
                        end
                    end
                end
            end
            if (state_reg == ST_SQRT && !sqrt_busy && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            kind_reg <= s_tuser[0];
            pix_reg  <= s_tdata;
        end
        if (state_reg == ST_UPD && emit) begin
            gx_reg      <= gx_next;
            gy_reg      <= gy_next;
            row_idx_reg <= out_row_reg[POS_BITS-1:0];
            col_idx_reg <= out_col_reg[POS_BITS-1:0];
            last_reg    <= (out_row_reg + ROW_BITS'(1) == eff_h)
                        && ({1'b0, out_col_reg} + CFG_BITS'(1) == eff_w);
        end
        if (state_reg == ST_CALC) begin
            strength_reg <= GRAD_BITS'({1'b0, ax} + {1'b0, ay});
            dir_reg      <= dir_c;
        end
        if (state_reg == ST_SQRT && !sqrt_busy && out_free) begin
            m_tdata_reg <= {6'b0, col_idx_reg, row_idx_reg, dir_reg, sqrt_root,
                            strength_reg, gy_reg, gx_reg};
            m_tlast_reg <= last_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

FILE: tb/sv/sobel_gradient_direction_test.sv
`timescale 1ns / 1ps
module sobel_gradient_direction_test;
    import sgd_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 60;

    typedef struct {
        logic       kind;
        logic [7:0] pixel;
    } pix_item_t;

    typedef struct {
        logic [10:0] grad_x;
        logic [10:0] grad_y;
        logic [10:0] strength;
        logic [10:0] magnitude;
        logic [1:0]  direction;
        logic [9:0]  row_index;
        logic [9:0]  col_index;
        logic        frame_last;
    } grad_result_t;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;    // [7:0] pixel
    logic [0:0]  s_tuser = '0;    // [0] kind
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;         // grad_x, grad_y, strength, magnitude, direction,
                                  // row_index, col_index from bit 0 up
    logic        m_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    always #4 aclk = ~aclk;

    sobel_gradient_direction i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    pix_item_t    pending_pixels[$];
    grad_result_t expected_grads[$];
    pix_item_t    offered;
    idle_mode_t   idle_mode = IDLE_NONE;
    bit           in_taken = 1'b0;
    int           hold_cycles = 0;
    int           quiet_cycles = 0;
    int           errors = 0;

    // shadow of the block's frame state
    logic [10:0] cfg_width = 11'd320;
    logic [10:0] cfg_height = 11'd240;
    logic [7:0]  row_older[MAX_WIDTH];
    logic [7:0]  row_newer[MAX_WIDTH];
    int          win[3][3];
    int          in_col, in_row, out_col, out_row;

    function automatic int eff_width();
        if (cfg_width < 3) return 3;
        if (cfg_width > MAX_WIDTH) return MAX_WIDTH;
        return cfg_width;
    endfunction

    function automatic int eff_height();
        if (cfg_height < 3) return 3;
        if (cfg_height > 1024) return 1024;
        return cfg_height;
    endfunction

    function automatic void restart_frame();
        in_col = 0;
        in_row = 0;
        out_col = 0;
        out_row = 0;
        foreach (win[r, c]) win[r][c] = 0;
    endfunction

    function automatic void shift_window(int t, int m, int b);
        int v[3];
        v[0] = t;
        v[1] = m;
        v[2] = b;
        for (int r = 0; r < 3; r++) begin
            win[r][0] = win[r][1];
            win[r][1] = win[r][2];
            win[r][2] = v[r];
        end
    endfunction

    function automatic int floor_root(int v);
        int r;
        r = 0;
        for (int b = 10; b >= 0; b--) begin
            if ((r | (1 << b)) * (r | (1 << b)) <= v) r = r | (1 << b);
        end
        return r;
    endfunction

    function automatic logic [1:0] direction_bin(int gx, int gy);
        longint ax, ay;
        if (gx == 0) return DIR_VERT;
        ax = gx < 0 ? -gx : gx;
        ay = gy < 0 ? -gy : gy;
        if (ay * 65536 <= ax * longint'(TAN_LO)) return DIR_HORZ;
        if ((gx > 0) == (gy > 0))
            return (ay * 65536 <= ax * longint'(TAN_HI)) ? DIR_DIAG_POS : DIR_VERT;
        return (ay * 65536 < ax * longint'(TAN_HI)) ? DIR_DIAG_NEG : DIR_VERT;
    endfunction

    function automatic void emit_gradient();
        grad_result_t g;
        int gx, gy, ax, ay;
        gx = (win[0][2] + 2 * win[1][2] + win[2][2]) - (win[0][0] + 2 * win[1][0] + win[2][0]);
        gy = (win[0][0] + 2 * win[0][1] + win[0][2]) - (win[2][0] + 2 * win[2][1] + win[2][2]);
        ax = gx < 0 ? -gx : gx;
        ay = gy < 0 ? -gy : gy;
        g.grad_x     = gx[10:0];
        g.grad_y     = gy[10:0];
        g.strength   = 11'(ax + ay);
        g.magnitude  = 11'(floor_root(ax * ax + ay * ay));
        g.direction  = direction_bin(gx, gy);
        g.row_index  = 10'(out_row);
        g.col_index  = 10'(out_col);
        g.frame_last = (out_row + 1 == eff_height()) && (out_col + 1 == eff_width());
        expected_grads = {expected_grads, g};
        if (out_col + 1 >= eff_width()) begin
            out_col = 0;
            out_row++;
        end else begin
            out_col++;
        end
    endfunction

    function automatic void predict_gradient(pix_item_t it);
        int w, h, idx, top, mid;
        w = eff_width();
        h = eff_height();
        if (it.kind == KIND_FLUSH) begin
            if (in_row < h || out_row >= h) return;
            if (out_col + 1 >= w) begin
                shift_window(0, 0, 0);
                emit_gradient();
                foreach (win[r, c]) win[r][c] = 0;
                shift_window(row_older[0], row_newer[0], 0);
            end else begin
                idx = out_col + 1 < MAX_WIDTH ? out_col + 1 : MAX_WIDTH - 1;
                shift_window(row_older[idx], row_newer[idx], 0);
                emit_gradient();
            end
            if (out_row >= h) restart_frame();
            return;
        end
        if (in_row >= h) restart_frame();
        idx = in_col < MAX_WIDTH ? in_col : MAX_WIDTH - 1;
        top = in_row >= 2 ? row_older[idx] : 0;
        mid = in_row >= 1 ? row_newer[idx] : 0;
        row_older[idx] = row_newer[idx];
        row_newer[idx] = it.pixel;
        if (in_col == 0) begin
            if (in_row >= 2) begin
                shift_window(0, 0, 0);
                emit_gradient();
            end
            foreach (win[r, c]) win[r][c] = 0;
            shift_window(top, mid, it.pixel);
        end else begin
            shift_window(top, mid, it.pixel);
            if (in_row >= 1) emit_gradient();
        end
        if (in_col + 1 >= w) begin
            in_col = 0;
            in_row++;
        end else begin
            in_col++;
        end
    endfunction

    function automatic void check_field(string name, int unsigned exp_v, int unsigned act_v);
        if (exp_v !== act_v) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
        end
    endfunction

    // sampling side: results, predictions and the watchdog
    always @(posedge aclk) begin
        grad_result_t exp_g;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (expected_grads.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result transaction, actual %h last %b",
                             $time, m_tdata, m_tlast);
                end else begin
                    exp_g = expected_grads.pop_front();
                    check_field("grad_x", exp_g.grad_x, m_tdata[10:0]);
                    check_field("grad_y", exp_g.grad_y, m_tdata[21:11]);
                    check_field("strength", exp_g.strength, m_tdata[32:22]);
                    check_field("magnitude", exp_g.magnitude, m_tdata[43:33]);
                    check_field("direction", exp_g.direction, m_tdata[45:44]);
                    check_field("row_index", exp_g.row_index, m_tdata[55:46]);
                    check_field("col_index", exp_g.col_index, m_tdata[65:56]);
                    check_field("frame_last", exp_g.frame_last, m_tlast);
                end
            end
            in_taken = s_tvalid && s_tready;
            if (in_taken) predict_gradient(offered);
            if (in_taken || (m_tvalid && m_tready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_LIMIT) begin
                    $display("FAILURE");
                    $finish;
                end
            end
        end
    end

    // pixel driver
    always @(negedge aclk) begin
        bit go;
        if (aresetn && (!s_tvalid || in_taken)) begin
            in_taken = 1'b0;
            go = pending_pixels.size() > 0;
            if (idle_mode == IDLE_SENDER && $urandom_range(99) < 74) go = 0;
            if (idle_mode == IDLE_BOTH && $urandom_range(99) < 8) go = 0;
            if (go) begin
                offered = pending_pixels.pop_front();
                s_tdata <= offered.pixel;
                s_tuser <= offered.kind;
            end
            s_tvalid <= go;
        end
    end

    // result receiver, with a long hold-off on request
    always @(negedge aclk) begin
        if (hold_cycles > 0) begin
            hold_cycles--;
            m_tready <= 1'b0;
        end else if (idle_mode == IDLE_RECEIVER) begin
            m_tready <= $urandom_range(99) >= 74;
        end else if (idle_mode == IDLE_BOTH) begin
            m_tready <= $urandom_range(99) >= 8;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic write_reg(logic reg_idx, logic [31:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_idx == REG_WIDTH) cfg_width = value[10:0];
        else cfg_height = value[10:0];
    endtask

    // block must be idle before a register write
    task automatic wait_drained();
        while (pending_pixels.size() > 0 || s_tvalid || expected_grads.size() > 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic set_frame_size(int unsigned w, int unsigned h);
        wait_drained();
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
    endtask

    function automatic void queue_item(logic kind, logic [7:0] px);
        pix_item_t it;
        it.kind = kind;
        it.pixel = px;
        pending_pixels = {pending_pixels, it};
    endfunction

    // style 0: random gray, 1: hard black/white edges; drain < 0 drains fully
    function automatic int queue_frame(int w, int h, int style, int drain, int noise_pct);
        int n;
        n = 0;
        for (int i = 0; i < w * h; i++) begin
            if ($urandom_range(99) < noise_pct) queue_item(KIND_FLUSH, 8'($urandom));
            if (style == 1) queue_item(KIND_PIXEL, $urandom_range(1) ? 8'hff : 8'h00);
            else queue_item(KIND_PIXEL, 8'($urandom));
            n++;
        end
        for (int i = 0; i < (drain < 0 ? w + 1 : drain); i++)
            queue_item(KIND_FLUSH, 8'($urandom));
        return n;
    endfunction

    task automatic random_phase(idle_mode_t mode, int budget);
        int w, h, n, done;
        idle_mode = mode;
        done = 0;
        while (done < budget) begin
            w = $urandom_range(15) == 0 ? $urandom_range(2) : $urandom_range(24, 3);
            h = $urandom_range(15) == 0 ? $urandom_range(2) : $urandom_range(10, 3);
            set_frame_size(w, h);
            w = w < 3 ? 3 : w;
            h = h < 3 ? 3 : h;
            n = $urandom_range(3, 1);
            for (int f = 0; f < n; f++) begin
                // earlier frames may be cut short in the drain by the next frame
                done += queue_frame(w, h, $urandom_range(3) == 0,
                                    (f < n - 1 && $urandom_range(1)) ? $urandom_range(w) : -1,
                                    4);
            end
            if ($urandom_range(3) == 0) queue_item(KIND_FLUSH, 8'($urandom));
        end
    endtask

    initial begin
        int dummy;
        restart_frame();
        foreach (row_older[i]) begin
            row_older[i] = '0;
            row_newer[i] = '0;
        end
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        // directed: smallest frame via clamped register values, hard edges,
        // a flush with nothing pending, pixels while draining
        set_frame_size(0, 2);
        queue_item(KIND_FLUSH, 8'hff);
        queue_item(KIND_PIXEL, 8'hff);
        queue_item(KIND_PIXEL, 8'h00);
        queue_item(KIND_PIXEL, 8'hff);
        queue_item(KIND_PIXEL, 8'h00);
        queue_item(KIND_PIXEL, 8'hff);
        queue_item(KIND_PIXEL, 8'h00);
        queue_item(KIND_PIXEL, 8'hff);
        queue_item(KIND_PIXEL, 8'hff);
        queue_item(KIND_PIXEL, 8'h00);
        queue_item(KIND_FLUSH, 8'h00);
        queue_item(KIND_FLUSH, 8'h5a);
        dummy = queue_frame(3, 3, 1, 2, 0);
        dummy = queue_frame(3, 3, 0, -1, 0);
        queue_item(KIND_FLUSH, 8'h00);

        // long receiver hold-off so the input backs up
        set_frame_size(40, 6);
        hold_cycles = 600;
        dummy = queue_frame(40, 6, 0, -1, 0);

        random_phase(IDLE_NONE, 200);
        random_phase(IDLE_SENDER, 200);
        random_phase(IDLE_RECEIVER, 200);
        random_phase(IDLE_BOTH, 200);
        idle_mode = IDLE_NONE;
        set_frame_size(320, 240);

        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

FILE: sobel_gradient_direction.f
rtl/core/sgd_pkg.sv
rtl/core/sgd_line_ram.sv
rtl/core/sgd_sqrt.sv
rtl/core/sobel_gradient_direction.sv
tb/sv/sobel_gradient_direction_test.sv
